// File: rtl/npc_pkg.sv
package npc_pkg;

    localparam int NUM_FEATURES    = 7;
    localparam int DEF_NUM_CLASSES = 5;
    localparam int LISTED_CLASSES  = 5;
    localparam int MAX_CLASSES     = 16;
    localparam int FEAT_W          = 16;
    localparam int FIDX_W          = 3;
    localparam int SEL_W           = 3;
    localparam int CLS_W           = 4;
    localparam int OUT_CLS_W       = 3;
    localparam int ALPHA_W         = 16;
    localparam int DIST_W          = 37;
    localparam int SQ_W            = 32;
    localparam int PROD_W          = 34;
    localparam int SPAN_W          = 13;
    localparam int NUM_W           = 29;
    localparam int RECIP_SHIFT     = 29;
    localparam int RECIP_W         = 25;
    localparam int QUO_W           = 17;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_UPDATE   = 1'b1;

    localparam int SPAN0 = 50;
    localparam int SPAN1 = 30;
    localparam int SPAN2 = 5000;
    localparam int SPAN3 = 200;
    localparam int SPAN4 = 750;
    localparam int SPAN5 = 700;
    localparam int SPAN6 = 4600;

    localparam int RECIP0 = ((1 << RECIP_SHIFT) + SPAN0 - 1) / SPAN0;
    localparam int RECIP1 = ((1 << RECIP_SHIFT) + SPAN1 - 1) / SPAN1;
    localparam int RECIP2 = ((1 << RECIP_SHIFT) + SPAN2 - 1) / SPAN2;
    localparam int RECIP3 = ((1 << RECIP_SHIFT) + SPAN3 - 1) / SPAN3;
    localparam int RECIP4 = ((1 << RECIP_SHIFT) + SPAN4 - 1) / SPAN4;
    localparam int RECIP5 = ((1 << RECIP_SHIFT) + SPAN5 - 1) / SPAN5;
    localparam int RECIP6 = ((1 << RECIP_SHIFT) + SPAN6 - 1) / SPAN6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic                opcode;
        logic [15:0]         carbon_dioxide;
        logic signed [10:0]  soil_temperature;
        logic [9:0]          moisture_level;
        logic [9:0]          interval_variation;
        logic [15:0]         mean_amplitude;
        logic [9:0]          relay_count;
        logic [9:0]          firing_rate;
        logic [SEL_W-1:0]    class_select;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              upd;
        logic [SEL_W-1:0]  sel;
        logic [FIDX_W-1:0] widx;
        logic [FEAT_W-1:0] feat;
    } beat_t;

    typedef struct packed {
        logic              valid;
        logic              upd;
        logic [CLS_W-1:0]  cls;
        logic [DIST_W-1:0] score;
    } best_t;

    function automatic logic signed [16:0] range_lo(input logic [FIDX_W-1:0] idx);
        case (idx)
            3'd4:    range_lo = 17'sd50;
            3'd5:    range_lo = -17'sd100;
            3'd6:    range_lo = 17'sd400;
            default: range_lo = 17'sd0;
        endcase
    endfunction

    function automatic logic signed [16:0] range_hi(input logic [FIDX_W-1:0] idx);
        case (idx)
            3'd0:    range_hi = 17'sd50;
            3'd1:    range_hi = 17'sd30;
            3'd2:    range_hi = 17'sd5000;
            3'd3:    range_hi = 17'sd200;
            3'd4:    range_hi = 17'sd800;
            3'd5:    range_hi = 17'sd600;
            default: range_hi = 17'sd5000;
        endcase
    endfunction

    function automatic logic [SPAN_W-1:0] span(input logic [FIDX_W-1:0] idx);
        case (idx)
            3'd0:    span = SPAN_W'(SPAN0);
            3'd1:    span = SPAN_W'(SPAN1);
            3'd2:    span = SPAN_W'(SPAN2);
            3'd3:    span = SPAN_W'(SPAN3);
            3'd4:    span = SPAN_W'(SPAN4);
            3'd5:    span = SPAN_W'(SPAN5);
            default: span = SPAN_W'(SPAN6);
        endcase
    endfunction

    function automatic logic [RECIP_W-1:0] recip(input logic [FIDX_W-1:0] idx);
        case (idx)
            3'd0:    recip = RECIP_W'(RECIP0);
            3'd1:    recip = RECIP_W'(RECIP1);
            3'd2:    recip = RECIP_W'(RECIP2);
            3'd3:    recip = RECIP_W'(RECIP3);
            3'd4:    recip = RECIP_W'(RECIP4);
            3'd5:    recip = RECIP_W'(RECIP5);
            default: recip = RECIP_W'(RECIP6);
        endcase
    endfunction

    function automatic logic [FEAT_W-1:0] centroid(input int c, input int f);
        logic [FEAT_W-1:0] row [LISTED_CLASSES][NUM_FEATURES];
        row[0] = '{16'd1311,  16'd0,     16'd3277,  16'd32768, 16'd32768, 16'd26214, 16'd1311};
        row[1] = '{16'd9830,  16'd3277,  16'd13107, 16'd19661, 16'd39322, 16'd29491, 16'd6554};
        row[2] = '{16'd16384, 16'd39322, 16'd22938, 16'd16384, 16'd42598, 16'd32768, 16'd9830};
        row[3] = '{16'd45875, 16'd13107, 16'd39322, 16'd52429, 16'd13107, 16'd49152, 16'd39322};
        row[4] = '{16'd29491, 16'd9830,  16'd52429, 16'd58982, 16'd9830,  16'd36045, 16'd26214};
        if (c < LISTED_CLASSES)
            centroid = row[c][f];
        else
            centroid = '0;
    endfunction

endpackage

// File: rtl/npc_normalizer.sv
module npc_normalizer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       issue,
    input  logic [npc_pkg::FIDX_W-1:0] issue_idx,
    input  npc_pkg::item_t             item,
    output npc_pkg::beat_t             beat
);
    import npc_pkg::*;

    logic signed [16:0] raw;
    logic signed [16:0] clamped;
    logic signed [16:0] offset;
    logic [SPAN_W-1:0]  v;
    logic [NUM_W-1:0]   n_next;

    logic               s0_valid_reg;
    logic [FIDX_W-1:0]  s0_idx_reg;
    logic [NUM_W-1:0]   s0_n_reg;
    logic               s1_valid_reg;
    logic [FIDX_W-1:0]  s1_idx_reg;
    logic [NUM_W-1:0]   s1_n_reg;
    logic [NUM_W+RECIP_W-1:0] s1_prod_reg;
    logic [NUM_W+RECIP_W-1:0] prod_next;
    logic [QUO_W-1:0]   q0;
    logic [QUO_W+SPAN_W-1:0] back;
    logic [QUO_W-1:0]   q;
    beat_t              beat_reg;
    beat_t              beat_next;

    always_comb
    begin
        case (issue_idx)
            3'd0:    raw = $signed({7'd0, item.firing_rate});
            3'd1:    raw = $signed({7'd0, item.relay_count});
            3'd2:    raw = $signed({1'b0, item.mean_amplitude});
            3'd3:    raw = $signed({7'd0, item.interval_variation});
            3'd4:    raw = $signed({7'd0, item.moisture_level});
            3'd5:    raw = 17'(item.soil_temperature);
            default: raw = $signed({1'b0, item.carbon_dioxide});
        endcase
        if (raw < range_lo(issue_idx))
            clamped = range_lo(issue_idx);
        else if (raw > range_hi(issue_idx))
            clamped = range_hi(issue_idx);
        else
            clamped = raw;
        offset = clamped - range_lo(issue_idx);
        v      = offset[SPAN_W-1:0];
        n_next = {v, 16'd0} - NUM_W'(v);
    end

    assign prod_next = s0_n_reg * recip(s0_idx_reg);

    always_comb
    begin
        q0   = s1_prod_reg[RECIP_SHIFT +: QUO_W];
        back = q0 * span(s1_idx_reg);
        if (back > (QUO_W+SPAN_W)'(s1_n_reg))
            q = q0 - 1'b1;
        else
            q = q0;
        beat_next       = '0;
        beat_next.valid = s1_valid_reg;
        beat_next.first = (s1_idx_reg == '0);
        beat_next.last  = (s1_idx_reg == FIDX_W'(NUM_FEATURES - 1));
        beat_next.upd   = (item.opcode == OP_UPDATE);
        beat_next.sel   = item.class_select;
        beat_next.widx  = s1_idx_reg;
        beat_next.feat  = q[FEAT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            beat_reg     <= '0;
        end
        else
        begin
            s0_valid_reg <= issue;
            s1_valid_reg <= s0_valid_reg;
            beat_reg     <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_idx_reg  <= issue_idx;
        s0_n_reg    <= n_next;
        s1_idx_reg  <= s0_idx_reg;
        s1_n_reg    <= s0_n_reg;
        s1_prod_reg <= prod_next;
    end

    assign beat = beat_reg;

endmodule

// File: rtl/npc_cell.sv
module npc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [npc_pkg::ALPHA_W-1:0] alpha,
    input  npc_pkg::beat_t              beat_in,
    input  npc_pkg::best_t              best_in,
    output npc_pkg::beat_t              beat_out,
    output npc_pkg::best_t              best_out
);
    import npc_pkg::*;

    localparam logic [CLS_W-1:0] MY_CLS = CLS_W'(CELL_INDEX);

    logic [FEAT_W-1:0]        row_reg [NUM_FEATURES];
    logic [FEAT_W-1:0]        p;
    logic signed [16:0]       diff;
    logic signed [16:0]       mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W:0]   upd_sum;
    logic                     write_en;
    logic [FEAT_W-1:0]        p_next;

    beat_t                    fwd_reg;
    logic                     b_valid_reg;
    logic                     b_first_reg;
    logic                     b_last_reg;
    logic                     b_upd_reg;
    logic [FIDX_W-1:0]        b_widx_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [DIST_W-1:0]        wterm;
    logic [DIST_W-1:0]        acc_reg;
    logic [DIST_W-1:0]        acc_next;
    best_t                    best_reg;
    best_t                    best_next;

    always_comb
    begin
        p        = row_reg[0];
        diff     = $signed({1'b0, beat_in.feat}) - $signed({1'b0, p});
        mul_b    = beat_in.upd ? $signed({1'b0, alpha}) : diff;
        prod     = diff * mul_b;
        upd_sum  = $signed({3'd0, p, 16'd0}) + (PROD_W+1)'(prod) + (PROD_W+1)'(32768);
        write_en = beat_in.upd && (CLS_W'(beat_in.sel) == MY_CLS);
        p_next   = write_en ? upd_sum[31:16] : p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < NUM_FEATURES; f++)
                row_reg[f] <= centroid(CELL_INDEX, f);
        end
        else if (beat_in.valid)
        begin
            for (int f = 0; f < NUM_FEATURES - 1; f++)
                row_reg[f] <= row_reg[f+1];
            row_reg[NUM_FEATURES-1] <= p_next;
        end
    end

    always_comb
    begin
        case (b_widx_reg) inside
            3'd0, 3'd1: wterm = DIST_W'({sq_reg, 2'b00});
            3'd2, 3'd3: wterm = DIST_W'({sq_reg, 1'b0}) + DIST_W'(sq_reg);
            3'd6:       wterm = DIST_W'({sq_reg, 1'b0});
            default:    wterm = DIST_W'(sq_reg);
        endcase
        acc_next = (b_first_reg ? '0 : acc_reg) + wterm;
        best_next       = best_in;
        best_next.valid = b_valid_reg && b_last_reg;
        best_next.upd   = b_upd_reg;
        if (CELL_INDEX == 0 || acc_next < best_in.score)
        begin
            best_next.cls   = MY_CLS;
            best_next.score = acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg     <= '0;
            b_valid_reg <= 1'b0;
            best_reg    <= '0;
        end
        else
        begin
            fwd_reg     <= beat_in;
            b_valid_reg <= beat_in.valid;
            best_reg    <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_first_reg <= beat_in.first;
        b_last_reg  <= beat_in.last;
        b_upd_reg   <= beat_in.upd;
        b_widx_reg  <= beat_in.widx;
        sq_reg      <= prod[SQ_W-1:0];
        if (b_valid_reg)
            acc_reg <= acc_next;
    end

    assign beat_out = fwd_reg;
    assign best_out = best_reg;

endmodule

// File: rtl/nearest_prototype_classifier.sv
// Weighted nearest-prototype classifier with adaptive prototypes.
// Input beats arrive on the s_axis channel: tuser carries the opcode and tdata
// the class select and the seven raw epoch features. A classify beat yields
// one beat on m_axis holding the nearest class; an update beat moves the
// selected prototype toward the epoch and yields nothing, and an update of a
// class that does not exist is dropped.
// The cfg channel writes the moving-average weight and is always ready; write
// it only while the block is idle.
// One beat is taken at a time. Seven features are normalized one per cycle,
// then pass along a row of NUM_CLASSES cells, one cell per cycle, each cell
// holding one prototype and one multiplier. A beat passes through the
// normalizer and then every cell to its result, and s_axis_tready returns in
// the cycle the result appears, so a new beat is taken only once the last one
// is through.
// Results wait in a two-entry output buffer, so a stalled receiver holds at
// most two results; s_axis_tready stays low while both entries are full.
// Reset restores the listed centroids and the default weight at once, with
// no clearing pass, and empties the output buffer.
module nearest_prototype_classifier #(
    parameter int NUM_CLASSES = npc_pkg::DEF_NUM_CLASSES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: class_select, firing_rate, relay_count,
    // mean_amplitude, interval_variation, moisture_level, soil_temperature,
    // carbon_dioxide.
    input  logic [87:0] s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: class_index.
    output logic [7:0]  m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import npc_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [FIDX_W-1:0]  fcnt_reg;
    logic [FIDX_W-1:0]  fcnt_next;
    item_t              item_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic               accept;
    logic               issue;
    logic               done;
    logic               push;
    logic               pop;

    logic [OUT_CLS_W-1:0] ent0_reg;
    logic [OUT_CLS_W-1:0] ent1_reg;
    logic [1:0]           count_reg;

    beat_t beat_chain [NUM_CLASSES+1];
    best_t best_chain [NUM_CLASSES+1];

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        fcnt_next  = fcnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FEED;
                    fcnt_next  = '0;
                end
            end
            ST_FEED:
            begin
                fcnt_next = fcnt_reg + 1'b1;
                if (fcnt_reg == FIDX_W'(NUM_FEATURES - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_axis_tready = (count_reg != 2'd2);
            ST_FEED:  issue = 1'b1;
            ST_DRAIN: issue = 1'b0;
            default:  issue = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fcnt_reg  <= '0;
            alpha_reg <= ALPHA_RESET;
        end
        else
        begin
            state_reg <= state_next;
            fcnt_reg  <= fcnt_next;
            if (cfg_valid && cfg_ready)
                alpha_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= {s_axis_tuser, s_axis_tdata[85:0]};
    end

    npc_normalizer u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .issue_idx (fcnt_reg),
        .item      (item_reg),
        .beat      (beat_chain[0])
    );

    assign best_chain[0] = '0;

    for (genvar c = 0; c < NUM_CLASSES; c++)
    begin : g_cell
        npc_cell #(
            .CELL_INDEX (c)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .alpha    (alpha_reg),
            .beat_in  (beat_chain[c]),
            .best_in  (best_chain[c]),
            .beat_out (beat_chain[c+1]),
            .best_out (best_chain[c+1])
        );
    end

    assign done = best_chain[NUM_CLASSES].valid
               || (beat_chain[NUM_CLASSES].valid && 1'b0);
    assign push = done && !best_chain[NUM_CLASSES].upd;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent0_reg <= (count_reg == 2'd1) ? best_chain[NUM_CLASSES].cls[OUT_CLS_W-1:0]
                                            : ent1_reg;
            if (push)
                ent1_reg <= best_chain[NUM_CLASSES].cls[OUT_CLS_W-1:0];
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                ent0_reg <= best_chain[NUM_CLASSES].cls[OUT_CLS_W-1:0];
            else
                ent1_reg <= best_chain[NUM_CLASSES].cls[OUT_CLS_W-1:0];
        end
    end

    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = {5'd0, ent0_reg};

endmodule

// File: rtl/npc_checker.sv
module npc_checker #(
    parameter int NUM_CLASSES = npc_pkg::DEF_NUM_CLASSES
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [87:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [15:0] cfg_data
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Output beat changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0)
                          && (32'(m_axis_tdata[2:0]) < NUM_CLASSES))
    else $error("Class index out of range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input accepted while a beat is in progress.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> ##2 !s_axis_tready)
    else $error("Classify beat finished too early.");

endmodule

bind nearest_prototype_classifier npc_checker #(.NUM_CLASSES(NUM_CLASSES)) u_npc_checker (.*);
